// ----- hw/rtl/itnb_pkg.sv -----
// ----------------------------------------------------------------------------
// itnb_pkg
// Shared types, constants and helpers for the triangle normal and bounds core.
// ----------------------------------------------------------------------------
package itnb_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW   = $clog2(MAX_VERTICES + 1);
	localparam int CMPW = (CW > 15) ? CW : 15;

	localparam int CRW = 51;   // cross product component
	localparam int MW  = 50;   // cross product magnitude
	localparam int LW  = 62;   // sum of squares
	localparam int SW  = 63;   // shared subtractor width
	localparam int QW  = 15;   // quotient bits

	localparam logic [LW-1:0] NEAR_ZERO = LW'(281);
	localparam logic [QW-1:0] ONE_Q14   = QW'(16384);

	localparam logic KIND_TRI  = 1'b0;
	localparam logic KIND_MESH = 1'b1;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_APPEND   = 2'd1,
		CMD_TRIANGLE = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_code_t;

	typedef logic signed [23:0] coord_t;
	typedef logic signed [15:0] index_t;
	typedef logic signed [15:0] norm_t;
	typedef logic signed [24:0] edge_t;

	typedef struct packed {
		logic [1:0] command;
		index_t     index_a;
		index_t     index_b;
		index_t     index_c;
		coord_t     coord_x;
		coord_t     coord_y;
		coord_t     coord_z;
	} cmd_t;

	typedef struct packed {
		logic   kind;
		coord_t low_x;
		coord_t low_y;
		coord_t low_z;
		coord_t high_x;
		coord_t high_y;
		coord_t high_z;
		norm_t  normal_x;
		norm_t  normal_y;
		norm_t  normal_z;
		logic   accepted;
		logic   last;
	} res_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	typedef struct packed {
		logic  start;
		edge_t e1x;
		edge_t e1y;
		edge_t e1z;
		edge_t e2x;
		edge_t e2y;
		edge_t e2z;
	} nrm_req_t;

	typedef struct packed {
		logic  done;
		norm_t nx;
		norm_t ny;
		norm_t nz;
	} nrm_rsp_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_RD_A,
		C_RD_B,
		C_RD_C,
		C_LAT_C,
		C_NORM,
		C_TRI_OUT,
		C_REJ_OUT,
		C_MESH_OUT
	} core_state_t;

	typedef enum logic [3:0] {
		N_IDLE,
		N_CROSS,
		N_MAG,
		N_SHIFT,
		N_SQR,
		N_SQRT,
		N_DIV_INIT,
		N_DIV,
		N_DONE
	} nrm_state_t;

	function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
		coord_t m;
		m = a;
		if (b < m) m = b;
		if (c < m) m = c;
		return m;
	endfunction

	function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
		coord_t m;
		m = a;
		if (b > m) m = b;
		if (c > m) m = c;
		return m;
	endfunction

endpackage

// ----- hw/rtl/itnb_if.sv -----
// ----------------------------------------------------------------------------
// itnb_cmd_if / itnb_res_if
// Valid/ready channels for commands and result records.
// ----------------------------------------------------------------------------
interface itnb_cmd_if;
	import itnb_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface itnb_res_if;
	import itnb_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/indexed_triangle_normal_bounds_core.sv -----
// ----------------------------------------------------------------------------
// indexed_triangle_normal_bounds_core
// Vertex store, triangle bounds and unit normal, running mesh bounds.
// ----------------------------------------------------------------------------
// Takes one command transaction at a time; cmd.ready stays low until every
// record of that command has been placed in the output register. The time
// an accepted triangle takes is set by the 31-step square root and the three
// 15-step divisions on the normal unit's shared subtractor, plus range-shift
// steps when the cross product is large. A triangle whose cross product is
// near zero skips the root and divisions. Output stalls add to the time that
// each command takes. The last record may wait in the output register while
// the next command is taken.
// ----------------------------------------------------------------------------
module indexed_triangle_normal_bounds_core (
	input logic            clk,
	input logic            arst_n,
	itnb_cmd_if.sink       cmd,
	itnb_res_if.source     res
);
	import itnb_pkg::*;

	core_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q [3];
	vertex_t       va_q, vb_q, vc_q, rd_vtx;
	coord_t        mesh_low_q [3], mesh_high_q [3];
	logic          nonempty_q;
	logic          res_valid_q;
	res_t          res_q;

	logic          accept, out_free, tri_ok, store_room;
	cmd_code_t     code;
	coord_t        tri_lo [3], tri_hi [3];
	logic [71:0]   rd_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	nrm_req_t      nrm_req;
	nrm_rsp_t      nrm_rsp;

	function automatic logic idx_valid(index_t i, logic [CW-1:0] cnt);
		return !i[15] && (CMPW'(i[14:0]) < CMPW'(cnt));
	endfunction

	assign code       = cmd_code_t'(cmd.data.command);
	assign accept     = cmd.valid && cmd.ready;
	assign out_free   = !res_valid_q || res.ready;
	assign store_room = count_q < CW'(MAX_VERTICES);
	assign tri_ok     = idx_valid(cmd.data.index_a, count_q)
		&& idx_valid(cmd.data.index_b, count_q)
		&& idx_valid(cmd.data.index_c, count_q);
	assign rd_vtx     = vertex_t'(rd_data);

	itnb_ram #(.WIDTH(72), .DEPTH(MAX_VERTICES)) u_store (
		.clk     (clk),
		.wr_en   (accept && code == CMD_APPEND && store_room),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({cmd.data.coord_x, cmd.data.coord_y, cmd.data.coord_z}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	itnb_normal u_normal (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (nrm_req),
		.rsp    (nrm_rsp)
	);

	always_comb begin
		nrm_req.start = (state_q == C_LAT_C);
		nrm_req.e1x   = edge_t'(vb_q.x) - edge_t'(va_q.x);
		nrm_req.e1y   = edge_t'(vb_q.y) - edge_t'(va_q.y);
		nrm_req.e1z   = edge_t'(vb_q.z) - edge_t'(va_q.z);
		nrm_req.e2x   = edge_t'(rd_vtx.x) - edge_t'(va_q.x);
		nrm_req.e2y   = edge_t'(rd_vtx.y) - edge_t'(va_q.y);
		nrm_req.e2z   = edge_t'(rd_vtx.z) - edge_t'(va_q.z);
	end

	always_comb begin
		tri_lo[0] = min3(va_q.x, vb_q.x, vc_q.x);
		tri_lo[1] = min3(va_q.y, vb_q.y, vc_q.y);
		tri_lo[2] = min3(va_q.z, vb_q.z, vc_q.z);
		tri_hi[0] = max3(va_q.x, vb_q.x, vc_q.x);
		tri_hi[1] = max3(va_q.y, vb_q.y, vc_q.y);
		tri_hi[2] = max3(va_q.z, vb_q.z, vc_q.z);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			C_IDLE: begin
				if (accept) begin
					if (code == CMD_TRIANGLE) state_d = tri_ok ? C_RD_A : C_REJ_OUT;
					else state_d = C_MESH_OUT;
				end
			end
			C_RD_A:     state_d = C_RD_B;
			C_RD_B:     state_d = C_RD_C;
			C_RD_C:     state_d = C_LAT_C;
			C_LAT_C:    state_d = C_NORM;
			C_NORM:     if (nrm_rsp.done) state_d = C_TRI_OUT;
			C_TRI_OUT:  if (out_free) state_d = C_MESH_OUT;
			C_REJ_OUT:  if (out_free) state_d = C_MESH_OUT;
			C_MESH_OUT: if (out_free) state_d = C_IDLE;
			default:    state_d = C_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == C_IDLE);
		rd_en     = 1'b0;
		rd_addr   = idx_q[0];
		case (state_q)
			C_RD_A: begin rd_en = 1'b1; rd_addr = idx_q[0]; end
			C_RD_B: begin rd_en = 1'b1; rd_addr = idx_q[1]; end
			C_RD_C: begin rd_en = 1'b1; rd_addr = idx_q[2]; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			count_q     <= '0;
			nonempty_q  <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				mesh_low_q[i]  <= '0;
				mesh_high_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept && code == CMD_CLEAR) begin
				count_q    <= '0;
				nonempty_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					mesh_low_q[i]  <= '0;
					mesh_high_q[i] <= '0;
				end
			end
			if (accept && code == CMD_APPEND && store_room) count_q <= count_q + CW'(1);
			if (state_q == C_TRI_OUT && out_free) begin
				nonempty_q <= 1'b1;
				for (int i = 0; i < 3; i++) begin
					if (!nonempty_q || tri_lo[i] < mesh_low_q[i]) mesh_low_q[i] <= tri_lo[i];
					if (!nonempty_q || tri_hi[i] > mesh_high_q[i]) mesh_high_q[i] <= tri_hi[i];
				end
			end
			if ((state_q == C_TRI_OUT || state_q == C_REJ_OUT || state_q == C_MESH_OUT)
					&& out_free)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q[0] <= AW'(unsigned'(cmd.data.index_a));
			idx_q[1] <= AW'(unsigned'(cmd.data.index_b));
			idx_q[2] <= AW'(unsigned'(cmd.data.index_c));
		end
		if (state_q == C_RD_B) va_q <= rd_vtx;
		if (state_q == C_RD_C) vb_q <= rd_vtx;
		if (state_q == C_LAT_C) vc_q <= rd_vtx;
		if (out_free) begin
			case (state_q)
				C_TRI_OUT: begin
					res_q.kind     <= KIND_TRI;
					res_q.low_x    <= tri_lo[0];
					res_q.low_y    <= tri_lo[1];
					res_q.low_z    <= tri_lo[2];
					res_q.high_x   <= tri_hi[0];
					res_q.high_y   <= tri_hi[1];
					res_q.high_z   <= tri_hi[2];
					res_q.normal_x <= nrm_rsp.nx;
					res_q.normal_y <= nrm_rsp.ny;
					res_q.normal_z <= nrm_rsp.nz;
					res_q.accepted <= 1'b1;
					res_q.last     <= 1'b0;
				end
				C_REJ_OUT: begin
					res_q.kind     <= KIND_TRI;
					res_q.low_x    <= '0;
					res_q.low_y    <= '0;
					res_q.low_z    <= '0;
					res_q.high_x   <= '0;
					res_q.high_y   <= '0;
					res_q.high_z   <= '0;
					res_q.normal_x <= '0;
					res_q.normal_y <= '0;
					res_q.normal_z <= '0;
					res_q.accepted <= 1'b0;
					res_q.last     <= 1'b0;
				end
				C_MESH_OUT: begin
					res_q.kind     <= KIND_MESH;
					res_q.low_x    <= mesh_low_q[0];
					res_q.low_y    <= mesh_low_q[1];
					res_q.low_z    <= mesh_low_q[2];
					res_q.high_x   <= mesh_high_q[0];
					res_q.high_y   <= mesh_high_q[1];
					res_q.high_z   <= mesh_high_q[2];
					res_q.normal_x <= '0;
					res_q.normal_y <= '0;
					res_q.normal_z <= '0;
					res_q.accepted <= 1'b1;
					res_q.last     <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	a_done_in_norm: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_rsp.done |-> state_q == C_NORM)
		else $error("normal unit finished outside a triangle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_VERTICES))
		else $error("vertex count overflow");

	a_mesh_order: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> mesh_low_q[0] <= mesh_high_q[0] && mesh_low_q[1] <= mesh_high_q[1]
			&& mesh_low_q[2] <= mesh_high_q[2])
		else $error("mesh bounds inverted");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != C_IDLE)
		else $error("command transaction produced no record");
endmodule

// ----- hw/rtl/itnb_ram.sv -----
// ----------------------------------------------------------------------------
// itnb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itnb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule

// ----- hw/rtl/itnb_normal.sv -----
// ----------------------------------------------------------------------------
// itnb_normal
// Unit normal from two edges: cross product, range shift, sum of squares,
// bit-serial square root and three bit-serial divisions on one multiplier
// and one subtractor.
// ----------------------------------------------------------------------------
module itnb_normal (
	input  logic               clk,
	input  logic               arst_n,
	input  itnb_pkg::nrm_req_t req,
	output itnb_pkg::nrm_rsp_t rsp
);
	import itnb_pkg::*;

	nrm_state_t state_q, state_d;
	logic [4:0] step_q;
	logic [1:0] lane_q;

	edge_t e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [30:0] op_a, op_b;
	logic signed [61:0] prod_s1;

	logic signed [CRW-1:0] cr_q [3];
	logic [2:0]    neg_q;
	logic [MW-1:0] m_q [3];
	logic          shifted_q;
	logic [LW-1:0] l_q, l_next;
	logic [SW-1:0] x_q, res_q, bit_q, d_q;
	logic [QW-1:0] quo_q, quo_fin, quo_cap;
	norm_t         n_q [3];

	logic [SW-1:0] sub_a, sub_b;
	logic [SW:0]   sub_diff;
	logic          ge;
	logic          over;
	logic [30:0]   root;
	logic [1:0]    sel;
	logic [1:0]    cr_sel;
	norm_t         n_new;

	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge       = !sub_diff[SW];
	assign over     = (|m_q[0][MW-1:30]) || (|m_q[1][MW-1:30]) || (|m_q[2][MW-1:30]);
	assign l_next   = l_q + LW'(unsigned'(prod_s1));
	assign root     = (res_q[30:0] == '0) ? 31'd1 : res_q[30:0];
	assign quo_fin  = {quo_q[QW-2:0], ge};
	assign quo_cap  = (quo_fin > ONE_Q14) ? ONE_Q14 : quo_fin;
	assign n_new    = neg_q[lane_q] ? -norm_t'({1'b0, quo_cap}) : norm_t'({1'b0, quo_cap});
	assign sel      = step_q[1:0];
	assign cr_sel   = 2'((step_q - 5'd1) >> 1);

	always_comb begin
		sub_a = x_q;
		sub_b = d_q;
		if (state_q == N_SQRT) sub_b = res_q + bit_q;
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			N_CROSS: begin
				case (step_q)
					5'd0: begin op_a = 31'(e1y_q); op_b = 31'(e2z_q); end
					5'd1: begin op_a = 31'(e1z_q); op_b = 31'(e2y_q); end
					5'd2: begin op_a = 31'(e1z_q); op_b = 31'(e2x_q); end
					5'd3: begin op_a = 31'(e1x_q); op_b = 31'(e2z_q); end
					5'd4: begin op_a = 31'(e1x_q); op_b = 31'(e2y_q); end
					5'd5: begin op_a = 31'(e1y_q); op_b = 31'(e2x_q); end
					default: ;
				endcase
			end
			N_SQR: begin
				if (step_q < 5'd3) begin
					op_a = $signed({1'b0, m_q[sel][29:0]});
					op_b = $signed({1'b0, m_q[sel][29:0]});
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) prod_s1 <= op_a * op_b;

	always_comb begin
		state_d = state_q;
		case (state_q)
			N_IDLE:     if (req.start) state_d = N_CROSS;
			N_CROSS:    if (step_q == 5'd6) state_d = N_MAG;
			N_MAG:      state_d = N_SHIFT;
			N_SHIFT:    if (!over) state_d = N_SQR;
			N_SQR: begin
				if (step_q == 5'd3)
					state_d = (!shifted_q && l_next <= NEAR_ZERO) ? N_DONE : N_SQRT;
			end
			N_SQRT:     if (step_q == 5'd30) state_d = N_DIV_INIT;
			N_DIV_INIT: state_d = N_DIV;
			N_DIV: begin
				if (step_q == 5'd14) state_d = (lane_q == 2'd2) ? N_DONE : N_DIV_INIT;
			end
			N_DONE:     state_d = N_IDLE;
			default:    state_d = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			step_q  <= '0;
			lane_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				N_IDLE:     begin step_q <= '0; lane_q <= '0; end
				N_CROSS:    step_q <= step_q + 5'd1;
				N_SHIFT:    step_q <= '0;
				N_SQR:      step_q <= (step_q == 5'd3) ? 5'd0 : step_q + 5'd1;
				N_SQRT:     step_q <= (step_q == 5'd30) ? 5'd0 : step_q + 5'd1;
				N_DIV_INIT: step_q <= '0;
				N_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd14) lane_q <= lane_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (req.start) begin
					e1x_q <= req.e1x; e1y_q <= req.e1y; e1z_q <= req.e1z;
					e2x_q <= req.e2x; e2y_q <= req.e2y; e2z_q <= req.e2z;
				end
			end
			N_CROSS: begin
				if (step_q != 5'd0) begin
					if (step_q[0])
						cr_q[cr_sel] <= CRW'(prod_s1);
					else
						cr_q[cr_sel] <= cr_q[cr_sel] - CRW'(prod_s1);
				end
			end
			N_MAG: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= cr_q[i][CRW-1];
					m_q[i]   <= cr_q[i][CRW-1] ? MW'(-cr_q[i]) : MW'(cr_q[i]);
				end
				shifted_q <= 1'b0;
			end
			N_SHIFT: begin
				l_q <= '0;
				if (over) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
					shifted_q <= 1'b1;
				end
			end
			N_SQR: begin
				if (step_q != 5'd0) l_q <= l_next;
				if (step_q == 5'd3) begin
					x_q   <= SW'(l_next);
					res_q <= '0;
					bit_q <= SW'(1) << 60;
					n_q[0] <= '0;
					n_q[1] <= norm_t'({1'b0, ONE_Q14});
					n_q[2] <= '0;
				end
			end
			N_SQRT: begin
				if (ge) begin
					x_q   <= sub_diff[SW-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIV_INIT: begin
				x_q   <= (SW'(m_q[lane_q][29:0]) << 14) + SW'(root >> 1);
				d_q   <= SW'(root) << 14;
				quo_q <= '0;
			end
			N_DIV: begin
				if (ge) x_q <= sub_diff[SW-1:0];
				quo_q <= quo_fin;
				d_q   <= d_q >> 1;
				if (step_q == 5'd14) n_q[lane_q] <= n_new;
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == N_DONE);
		rsp.nx   = n_q[0];
		rsp.ny   = n_q[1];
		rsp.nz   = n_q[2];
	end
endmodule

// ----- tb/indexed_triangle_normal_bounds_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_triangle_normal_bounds_core_tb
// Drives command transactions (clear, append, triangle, unused code) through
// the core and checks every result record against a cycle-free predictor of
// the vertex store, triangle bounds, unit normal and running mesh bounds.
// ----------------------------------------------------------------------------
module indexed_triangle_normal_bounds_core_tb;
	import itnb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;

	itnb_cmd_if cmd_ch ();
	itnb_res_if res_ch ();

	indexed_triangle_normal_bounds_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.res    (res_ch.source)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	cmd_t   pending_cmds[$];
	res_t   expected_recs[$];
	int     error_count;
	int     cycle_count;
	bit     cmd_taken;
	int     tx_idle_pct;
	int     rx_stall_pct;
	int     rx_hold_cycles;

	// predictor state
	coord_t store_x[MAX_VERTICES];
	coord_t store_y[MAX_VERTICES];
	coord_t store_z[MAX_VERTICES];
	int     stored_count;
	coord_t mesh_lo[3];
	coord_t mesh_hi[3];
	bit     mesh_valid;

	// generator-side vertex count
	int     gen_count;

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (t=%0t)", field, got, want, $realtime);
		error_count++;
	endtask

	function automatic res_t mesh_record();
		res_t r;
		r = '0;
		r.kind = KIND_MESH;
		if (mesh_valid) begin
			r.low_x  = mesh_lo[0];
			r.low_y  = mesh_lo[1];
			r.low_z  = mesh_lo[2];
			r.high_x = mesh_hi[0];
			r.high_y = mesh_hi[1];
			r.high_z = mesh_hi[2];
		end
		r.accepted = 1'b1;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void unit_normal(input longint cr[3], output norm_t nv[3]);
		longint unsigned m[3];
		longint unsigned mx;
		longint unsigned sum_sq;
		longint unsigned root;
		longint unsigned rem;
		longint unsigned bit_v;
		longint unsigned q;
		int s;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = cr[i] < 0 ? longint'(-cr[i]) : longint'(cr[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx < (64'd1 << 30)) begin
			sum_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			if (sum_sq <= 281) begin
				nv[0] = '0;
				nv[1] = norm_t'(16384);
				nv[2] = '0;
				return;
			end
		end
		s = 0;
		while ((mx >> s) >= (64'd1 << 30)) s++;
		for (int i = 0; i < 3; i++) m[i] = m[i] >> s;
		sum_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		rem = sum_sq;
		root = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > rem) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (rem >= root + bit_v) begin
				rem = rem - (root + bit_v);
				root = (root >> 1) + bit_v;
			end else begin
				root = root >> 1;
			end
			bit_v = bit_v >> 2;
		end
		if (root == 0) root = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 14) + (root >> 1)) / root;
			if (q > 16384) q = 16384;
			nv[i] = cr[i] < 0 ? -norm_t'(q) : norm_t'(q);
		end
	endfunction

	task automatic predict_records(cmd_t c);
		res_t   tri_rec;
		longint ia, ib, ic;
		longint a[3], b[3], cc[3], e1[3], e2[3], cr[3];
		coord_t lo[3], hi[3];
		norm_t  nv[3];
		case (cmd_code_t'(c.command))
			CMD_CLEAR: begin
				stored_count = 0;
				mesh_valid = 1'b0;
				for (int k = 0; k < 3; k++) begin
					mesh_lo[k] = '0;
					mesh_hi[k] = '0;
				end
			end
			CMD_APPEND: begin
				if (stored_count < MAX_VERTICES) begin
					store_x[stored_count] = c.coord_x;
					store_y[stored_count] = c.coord_y;
					store_z[stored_count] = c.coord_z;
					stored_count++;
				end
			end
			CMD_TRIANGLE: begin
				tri_rec = '0;
				tri_rec.kind = KIND_TRI;
				ia = c.index_a;
				ib = c.index_b;
				ic = c.index_c;
				if (ia >= 0 && ia < stored_count && ib >= 0 && ib < stored_count &&
						ic >= 0 && ic < stored_count) begin
					a  = '{store_x[ia], store_y[ia], store_z[ia]};
					b  = '{store_x[ib], store_y[ib], store_z[ib]};
					cc = '{store_x[ic], store_y[ic], store_z[ic]};
					for (int k = 0; k < 3; k++) begin
						e1[k] = b[k] - a[k];
						e2[k] = cc[k] - a[k];
						lo[k] = coord_t'(a[k]);
						hi[k] = coord_t'(a[k]);
						if (b[k] < lo[k]) lo[k] = coord_t'(b[k]);
						if (cc[k] < lo[k]) lo[k] = coord_t'(cc[k]);
						if (b[k] > hi[k]) hi[k] = coord_t'(b[k]);
						if (cc[k] > hi[k]) hi[k] = coord_t'(cc[k]);
					end
					cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
					cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
					cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
					unit_normal(cr, nv);
					for (int k = 0; k < 3; k++) begin
						if (!mesh_valid || lo[k] < mesh_lo[k]) mesh_lo[k] = lo[k];
						if (!mesh_valid || hi[k] > mesh_hi[k]) mesh_hi[k] = hi[k];
					end
					mesh_valid = 1'b1;
					tri_rec.low_x = lo[0];
					tri_rec.low_y = lo[1];
					tri_rec.low_z = lo[2];
					tri_rec.high_x = hi[0];
					tri_rec.high_y = hi[1];
					tri_rec.high_z = hi[2];
					tri_rec.normal_x = nv[0];
					tri_rec.normal_y = nv[1];
					tri_rec.normal_z = nv[2];
					tri_rec.accepted = 1'b1;
				end
				expected_recs = {expected_recs, tri_rec};
			end
			default: ;
		endcase
		expected_recs = {expected_recs, mesh_record()};
	endtask

	// ---- stimulus helpers ----
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 32767)) - 16384);
			2: begin
				case ($urandom_range(0, 2))
					0: return 24'sh7FFFFF;
					1: return 24'sh800000;
					default: return 24'sh000000;
				endcase
			end
			default: return coord_t'($signed($urandom_range(0, 2097151)) - 1048576);
		endcase
	endfunction

	function automatic void add_append(coord_t x, coord_t y, coord_t z);
		cmd_t c;
		c = '0;
		c.command = CMD_APPEND;
		c.index_a = index_t'($urandom);
		c.index_b = index_t'($urandom);
		c.index_c = index_t'($urandom);
		c.coord_x = x;
		c.coord_y = y;
		c.coord_z = z;
		pending_cmds = {pending_cmds, c};
		if (gen_count < MAX_VERTICES) gen_count++;
	endfunction

	function automatic void add_triangle(index_t a, index_t b, index_t c_i);
		cmd_t c;
		c = '0;
		c.command = CMD_TRIANGLE;
		c.index_a = a;
		c.index_b = b;
		c.index_c = c_i;
		c.coord_x = coord_t'($urandom);
		c.coord_y = coord_t'($urandom);
		c.coord_z = coord_t'($urandom);
		pending_cmds = {pending_cmds, c};
	endfunction

	function automatic void add_simple(cmd_code_t code);
		cmd_t c;
		c = cmd_t'({$urandom, $urandom, $urandom, $urandom});
		c.command = code;
		pending_cmds = {pending_cmds, c};
		if (code == CMD_CLEAR) gen_count = 0;
	endfunction

	function automatic index_t good_index();
		return index_t'($urandom_range(0, gen_count - 1));
	endfunction

	function automatic index_t bad_index();
		case ($urandom_range(0, 2))
			0: return index_t'(-$signed($urandom_range(1, 32768)));
			1: return index_t'($urandom_range(gen_count, 32767));
			default: return index_t'($urandom);
		endcase
	endfunction

	function automatic void add_random_triangle();
		index_t ia, ib, ic;
		if (gen_count > 0 && $urandom_range(0, 99) < 85) begin
			ia = good_index();
			ib = good_index();
			ic = good_index();
			if ($urandom_range(0, 9) == 0) ib = ia;
		end else begin
			ia = gen_count > 0 ? good_index() : bad_index();
			ib = gen_count > 0 ? good_index() : bad_index();
			ic = gen_count > 0 ? good_index() : bad_index();
			case ($urandom_range(0, 2))
				0: ia = bad_index();
				1: ib = bad_index();
				default: ic = bad_index();
			endcase
		end
		add_triangle(ia, ib, ic);
	endfunction

	function automatic void add_random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) add_simple(CMD_CLEAR);
		else if (r < 4) add_simple(CMD_NONE);
		else if (r < 40 && gen_count < MAX_VERTICES)
			add_append(rand_coord(), rand_coord(), rand_coord());
		else add_random_triangle();
	endfunction

	task automatic drain();
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_recs.size() != 0)
			@(posedge clk);
	endtask

	// ---- driver ----
	always @(negedge clk) begin
		if (!cmd_ch.valid || cmd_taken) begin
			cmd_taken = 1'b0;
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				cmd_ch.data <= pending_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// ---- receiver ready ----
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			rx_hold_cycles--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// ---- acceptance, check, timeout ----
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("[FAIL] regression broken");
				$finish;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmd_taken = 1'b1;
				predict_records(cmd_ch.data);
			end
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (expected_recs.size() == 0) begin
					report_mismatch("unexpected record kind", got.kind, -1);
				end else begin
					want = expected_recs.pop_front();
					if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
					if (got.low_x != want.low_x) report_mismatch("low_x", got.low_x, want.low_x);
					if (got.low_y != want.low_y) report_mismatch("low_y", got.low_y, want.low_y);
					if (got.low_z != want.low_z) report_mismatch("low_z", got.low_z, want.low_z);
					if (got.high_x != want.high_x)
						report_mismatch("high_x", got.high_x, want.high_x);
					if (got.high_y != want.high_y)
						report_mismatch("high_y", got.high_y, want.high_y);
					if (got.high_z != want.high_z)
						report_mismatch("high_z", got.high_z, want.high_z);
					if (got.normal_x != want.normal_x)
						report_mismatch("normal_x", got.normal_x, want.normal_x);
					if (got.normal_y != want.normal_y)
						report_mismatch("normal_y", got.normal_y, want.normal_y);
					if (got.normal_z != want.normal_z)
						report_mismatch("normal_z", got.normal_z, want.normal_z);
					if (got.accepted != want.accepted)
						report_mismatch("accepted", got.accepted, want.accepted);
					if (got.last != want.last) report_mismatch("last", got.last, want.last);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		cmd_taken = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_cycles = 0;
		stored_count = 0;
		mesh_valid = 1'b0;
		gen_count = 0;
		for (int k = 0; k < 3; k++) begin
			mesh_lo[k] = '0;
			mesh_hi[k] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		add_triangle(0, 0, 0);
		add_simple(CMD_NONE);
		add_append(0, 0, 0);
		add_append(1, 0, 0);
		add_append(0, 1, 0);
		add_triangle(0, 1, 2);
		add_append(17, 0, 0);
		add_append(0, 17, 0);
		add_triangle(0, 3, 4);
		add_append(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		add_append(24'sh800000, 24'sh800000, 24'sh800000);
		add_append(24'sh7FFFFF, 24'sh800000, 24'sh000000);
		add_triangle(5, 6, 7);
		add_triangle(7, 5, 6);
		add_triangle(5, 5, 6);
		add_triangle(0, 1, 3);
		add_triangle(-1, 0, 1);
		add_triangle(0, 8, 1);
		add_triangle(0, 1, -32768);
		add_triangle(32767, 0, 1);
		add_simple(CMD_CLEAR);
		add_triangle(0, 0, 0);
		add_append(24'sh800000, 24'sh7FFFFF, 24'sh800000);
		drain();

		// random, three idle profiles
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = ph == 0 ? 6 : (ph == 1 ? 68 : 0);
			rx_stall_pct = ph == 0 ? 68 : (ph == 1 ? 6 : 0);
			if (ph == 2) rx_hold_cycles = 600;
			for (int i = 0; i < 30; i++) add_random_item();
			drain();
		end

		// fill the store past capacity, then address the top entries
		add_simple(CMD_CLEAR);
		for (int i = 0; i < MAX_VERTICES + 3; i++)
			add_append(rand_coord(), rand_coord(), rand_coord());
		for (int i = 0; i < 12; i++)
			add_triangle(index_t'(1023 - $urandom_range(0, 3)), good_index(), 1023);
		add_triangle(1024, 0, 1);
		drain();

		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- indexed_triangle_normal_bounds_core.f -----
hw/rtl/itnb_pkg.sv
hw/rtl/itnb_if.sv
hw/rtl/itnb_ram.sv
hw/rtl/itnb_normal.sv
hw/rtl/indexed_triangle_normal_bounds_core.sv
tb/indexed_triangle_normal_bounds_core_tb.sv
